[src/sstf_pkg.sv]
// sstf_pkg: shared constants, command control struct and back-end state type
// for the shortest-seek-first scheduler; no dependencies
package sstf_pkg;

    // default sizing of the request store and the track word
    localparam int DEPTH_DEF      = 64;
    localparam int TRACK_BITS_DEF = 16;

    // fixed port widths
    localparam int TRACK_W = 16;
    localparam int COST_W  = 22;

    // running cost saturates here
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // entries reduced per group in the first selection cycle
    localparam int GROUP_SIZE = 8;

    // entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // control part of one command from the front end
    typedef struct packed {
        logic wr;       // write the track into the store
        logic close;    // batch ends here, start picking
        logic dropped;  // some request of this batch was discarded
    } t_cmd_ctl;

    // back-end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_PICK
    } t_bstate;

endpackage

[src/sstf_front.sv]
// sstf_front: accepts request beats, assigns store slots, flags overflow
// depends on sstf_pkg
module sstf_front #(
    parameter int DEPTH      = sstf_pkg::DEPTH_DEF,
    parameter int TRACK_BITS = sstf_pkg::TRACK_BITS_DEF,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sstf_pkg::TRACK_W-1:0] i_track,
    input  logic                         i_last,
    input  logic                         i_q_full,
    output logic                         o_push,
    output sstf_pkg::t_cmd_ctl           o_cmd_ctl,
    output logic [IDX_W-1:0]             o_cmd_idx,
    output logic [TRACK_BITS-1:0]        o_cmd_track
);
    import sstf_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             w_accept;
    logic             w_room;

    // classify the incoming beat
    assign o_in_ready  = !i_q_full;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_room      = (r_count < CNT_W'(DEPTH));

    assign o_cmd_ctl.wr      = w_room;
    assign o_cmd_ctl.close   = i_last;
    assign o_cmd_ctl.dropped = r_ovf || !w_room;
    assign o_cmd_idx         = r_count[IDX_W-1:0];
    assign o_cmd_track       = TRACK_BITS'(i_track);

    // dropped non-closing beats need no command
    assign o_push = w_accept && (w_room || i_last);

    // per-batch fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_room) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

endmodule

[src/sstf_queue.sv]
// sstf_queue: small command fifo between front and back ends
// depends on sstf_pkg
module sstf_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);
    import sstf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[src/sstf_back.sv]
// sstf_back: request store, nearest-track selection and result register
// depends on sstf_pkg
module sstf_back #(
    parameter int DEPTH      = sstf_pkg::DEPTH_DEF,
    parameter int TRACK_BITS = sstf_pkg::TRACK_BITS_DEF,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sstf_pkg::TRACK_W-1:0] i_start_track,
    input  logic                         i_q_valid,
    input  sstf_pkg::t_cmd_ctl           i_cmd_ctl,
    input  logic [IDX_W-1:0]             i_cmd_idx,
    input  logic [TRACK_BITS-1:0]        i_cmd_track,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sstf_pkg::TRACK_W-1:0] o_visited_track,
    output logic [sstf_pkg::TRACK_W-1:0] o_seek_distance,
    output logic [sstf_pkg::COST_W-1:0]  o_total_cost,
    output logic                         o_dropped,
    output logic                         o_final_res
);
    import sstf_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int NGRP   = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NSLOT  = NGRP * GROUP_SIZE;
    localparam int SUM_W  = ((TRACK_BITS > COST_W) ? TRACK_BITS : COST_W) + 1;

    function automatic logic [TRACK_BITS-1:0] f_dist(
        input logic [TRACK_BITS-1:0] a,
        input logic [TRACK_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    t_bstate r_state;
    t_bstate n_state;

    logic [TRACK_BITS-1:0] r_store [DEPTH];
    logic [DEPTH-1:0]      r_visited;
    logic [TRACK_BITS-1:0] r_head;
    logic [COST_W-1:0]     r_cost;
    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_left;
    logic                  r_dropped;

    // group winners from the scan cycle
    logic [TRACK_BITS-1:0] r_gdist  [NGRP];
    logic [TRACK_BITS-1:0] r_gtrack [NGRP];
    logic [IDX_W-1:0]      r_gidx   [NGRP];
    logic [NGRP-1:0]       r_gok;
    logic [TRACK_BITS-1:0] n_gdist  [NGRP];
    logic [TRACK_BITS-1:0] n_gtrack [NGRP];
    logic [IDX_W-1:0]      n_gidx   [NGRP];
    logic [NGRP-1:0]       n_gok;

    // result register
    logic                  r_out_valid;
    logic [TRACK_W-1:0]    r_out_track;
    logic [TRACK_W-1:0]    r_out_dist;
    logic [COST_W-1:0]     r_out_cost;
    logic                  r_out_dropped;
    logic                  r_out_final;

    logic [TRACK_BITS-1:0] w_dist  [NSLOT];
    logic [TRACK_BITS-1:0] w_track [NSLOT];
    logic [NSLOT-1:0]      w_live;

    logic                  w_best_ok;
    logic [TRACK_BITS-1:0] w_best_dist;
    logic [TRACK_BITS-1:0] w_best_track;
    logic [IDX_W-1:0]      w_best_idx;
    logic [SUM_W-1:0]      w_sum;
    logic [COST_W-1:0]     n_cost;
    logic                  w_last_pick;
    logic                  w_scan;
    logic                  w_commit;
    logic                  w_start;
    logic [CNT_W-1:0]      w_batch_n;

    // per-entry distance to the head and eligibility
    for (genvar e = 0; e < NSLOT; e++) begin : g_slot
        if (e < DEPTH) begin : g_real
            assign w_track[e] = r_store[e];
            assign w_dist[e]  = f_dist(r_store[e], r_head);
            assign w_live[e]  = (r_n > CNT_W'(e)) && !r_visited[e];
        end else begin : g_pad
            assign w_track[e] = '0;
            assign w_dist[e]  = '0;
            assign w_live[e]  = 1'b0;
        end
    end

    // first level: nearest entry in each group, lowest index on a tie
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_gok[g]    = 1'b0;
            n_gdist[g]  = '0;
            n_gtrack[g] = '0;
            n_gidx[g]   = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (w_live[g*GROUP_SIZE+k]
                    && (!n_gok[g] || (w_dist[g*GROUP_SIZE+k] < n_gdist[g]))) begin
                    n_gok[g]    = 1'b1;
                    n_gdist[g]  = w_dist[g*GROUP_SIZE+k];
                    n_gtrack[g] = w_track[g*GROUP_SIZE+k];
                    n_gidx[g]   = IDX_W'(g*GROUP_SIZE+k);
                end
            end
        end
    end

    // second level: nearest over the group winners
    always_comb begin
        w_best_ok    = 1'b0;
        w_best_dist  = '0;
        w_best_track = '0;
        w_best_idx   = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_gok[g] && (!w_best_ok || (r_gdist[g] < w_best_dist))) begin
                w_best_ok    = 1'b1;
                w_best_dist  = r_gdist[g];
                w_best_track = r_gtrack[g];
                w_best_idx   = r_gidx[g];
            end
        end
    end

    // saturating running cost
    assign w_sum  = SUM_W'(r_cost) + SUM_W'(w_best_dist);
    assign n_cost = (w_sum > SUM_W'(COST_MAX)) ? COST_MAX : w_sum[COST_W-1:0];

    assign w_last_pick = (r_left == CNT_W'(1));
    assign w_batch_n   = i_cmd_ctl.wr ? (CNT_W'(i_cmd_idx) + 1'b1) : CNT_W'(DEPTH);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid && i_cmd_ctl.close) begin
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                n_state = B_PICK;
            end
            B_PICK: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = w_last_pick ? B_IDLE : B_SCAN;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        w_scan   = 1'b0;
        w_commit = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_pop = i_q_valid;
            end
            B_SCAN: begin
                w_scan = 1'b1;
            end
            B_PICK: begin
                w_commit = (!r_out_valid || i_out_ready) && w_best_ok;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign w_start = o_pop && i_cmd_ctl.close;

    // request store
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd_ctl.wr) begin
            r_store[i_cmd_idx] <= i_cmd_track;
        end
    end

    // group winner registers
    always_ff @(posedge i_clk) begin
        if (w_scan) begin
            r_gdist  <= n_gdist;
            r_gtrack <= n_gtrack;
            r_gidx   <= n_gidx;
        end
    end

    // batch payload: head, cost and flags
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_head    <= TRACK_BITS'(i_start_track);
            r_cost    <= '0;
            r_dropped <= i_cmd_ctl.dropped;
        end else if (w_commit) begin
            r_head <= w_best_track;
            r_cost <= n_cost;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_track   <= TRACK_W'(w_best_track);
            r_out_dist    <= TRACK_W'(w_best_dist);
            r_out_cost    <= n_cost;
            r_out_dropped <= r_dropped;
            r_out_final   <= w_last_pick;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_visited   <= '0;
            r_n         <= '0;
            r_left      <= '0;
            r_gok       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_scan) begin
                r_gok <= n_gok;
            end
            if (w_start) begin
                r_n    <= w_batch_n;
                r_left <= w_batch_n;
            end else if (w_commit) begin
                r_left <= r_left - 1'b1;
                if (w_last_pick) begin
                    r_visited <= '0;
                    r_n       <= '0;
                end else begin
                    r_visited[w_best_idx] <= 1'b1;
                end
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_visited_track = r_out_track;
    assign o_seek_distance = r_out_dist;
    assign o_total_cost    = r_out_cost;
    assign o_dropped       = r_out_dropped;
    assign o_final_res     = r_out_final;

endmodule

[src/sstf_disk_scheduler.sv]
// sstf_disk_scheduler: top level, start-track register, front end, command
// queue and back end; depends on sstf_pkg, sstf_front, sstf_queue, sstf_back
//
// Usage:
//   Request beats (i_track, i_last) come in on i_in_valid / o_in_ready and are
//   stored until a beat with i_last closes the batch. Result beats go out on
//   o_out_valid / i_out_ready, one per stored request, in nearest-track order
//   starting from the start track; o_final_res marks the last one.
//   The start track is written with i_cfg_we / i_cfg_wdata while idle.
//   Requests past the store depth are discarded; o_dropped then reads 1 on
//   every result of that batch.
//   Throughput: one request beat per cycle while the command queue has room.
//   For each result the back end first computes, in its scan state, all
//   distances and a nearest entry per group of eight; its pick state then
//   reduces the groups and commits the pick once the result register is free.
//   The first result follows the closing beat through the pop, the scan and
//   the pick into the result register.
//   The front end keeps taking the next batch into a 4-entry queue while the
//   back end still picks; beats wait there until the batch is finished.
//   Stall: a result waiting on i_out_ready holds the back end; the queue
//   fills and o_in_ready then drops.
//   Reset: synchronous, active low; clears the batch state, the queue, the
//   result valid flag and sets the start track to 0.
module sstf_disk_scheduler #(
    parameter int DEPTH      = sstf_pkg::DEPTH_DEF,
    parameter int TRACK_BITS = sstf_pkg::TRACK_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sstf_pkg::TRACK_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sstf_pkg::TRACK_W-1:0] i_track,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sstf_pkg::TRACK_W-1:0] o_visited_track,
    output logic [sstf_pkg::TRACK_W-1:0] o_seek_distance,
    output logic [sstf_pkg::COST_W-1:0]  o_total_cost,
    output logic                         o_dropped,
    output logic                         o_final_res
);
    import sstf_pkg::*;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CTL_W  = $bits(t_cmd_ctl);
    localparam int DATA_W = CTL_W + IDX_W + TRACK_BITS;

    logic [TRACK_W-1:0]    r_start_track;

    t_cmd_ctl              f_ctl;
    logic [IDX_W-1:0]      f_idx;
    logic [TRACK_BITS-1:0] f_track;
    logic                  q_push;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [DATA_W-1:0]     q_rdata;
    t_cmd_ctl              b_ctl;
    logic [IDX_W-1:0]      b_idx;
    logic [TRACK_BITS-1:0] b_track;

    // start track register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_track <= '0;
        end else if (i_cfg_we) begin
            r_start_track <= i_cfg_wdata;
        end
    end

    sstf_front #(
        .DEPTH      (DEPTH),
        .TRACK_BITS (TRACK_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_track     (i_track),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd_ctl   (f_ctl),
        .o_cmd_idx   (f_idx),
        .o_cmd_track (f_track)
    );

    sstf_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_ctl, f_idx, f_track}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    // unpack the queue head
    assign b_ctl   = q_rdata[DATA_W-1 -: CTL_W];
    assign b_idx   = q_rdata[TRACK_BITS +: IDX_W];
    assign b_track = q_rdata[TRACK_BITS-1:0];

    sstf_back #(
        .DEPTH      (DEPTH),
        .TRACK_BITS (TRACK_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start_track   (r_start_track),
        .i_q_valid       (q_valid),
        .i_cmd_ctl       (b_ctl),
        .i_cmd_idx       (b_idx),
        .i_cmd_track     (b_track),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_visited_track (o_visited_track),
        .o_seek_distance (o_seek_distance),
        .o_total_cost    (o_total_cost),
        .o_dropped       (o_dropped),
        .o_final_res     (o_final_res)
    );

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // back end only pops a present command
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // running cost never falls within a batch
    a_cost_rising: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_final_res)
            |=> (!o_out_valid || (o_total_cost >= $past(o_total_cost))))
        else $error("running cost decreased within a batch");

endmodule
